// ===== hw/rtl/lfu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU slot replacement block.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int MAX_SLOTS_DEF = 32;
   localparam int KEY_BITS_DEF  = 16;

   localparam int CSR_W     = 6;
   localparam int SLOT_W    = 5;
   localparam int EVKEY_W   = 16;
   localparam int COUNT_W   = 16;
   localparam int STAMP_W   = 32;

   localparam logic [CSR_W-1:0]   CSR_RESET = CSR_W'(32);
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_NEW = COUNT_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } lfu_state_type;

   typedef struct packed {
      logic               hit;
      logic [SLOT_W-1:0]  slot;
      logic               evicted_valid;
      logic [EVKEY_W-1:0] evicted_key;
   } rsp_beat_type;

endpackage

// ===== hw/rtl/lfu_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_mem
// Single-port-write, single-port-read slot memory with registered read data.
// ----------------------------------------------------------------------------
module lfu_mem #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5,
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/lfu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_ctrl
// Scan sequencer: reads every held slot once, tracks the first key match and
// the eviction candidate, then writes the chosen slot back.
// ----------------------------------------------------------------------------
module lfu_ctrl #(
   parameter int MAX_SLOTS = 32,
   parameter int KEY_BITS  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [KEY_BITS-1:0]         req_key,
   input  logic [lfu_pkg::CSR_W-1:0]   cap_cfg,
   input  logic                        res_free,
   output logic                        res_load,
   output lfu_pkg::rsp_beat_type       res_beat
);

   import lfu_pkg::*;

   localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int OCC_W = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W = (OCC_W > CSR_W) ? OCC_W : CSR_W;
   localparam int ENT_W = KEY_BITS + COUNT_W + STAMP_W;

   lfu_state_type state_ff, state_in;

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [OCC_W-1:0]    held_ff, held_in;
   logic [OCC_W-1:0]    issue_ff, issue_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    match_idx_ff, match_idx_in;
   logic [COUNT_W-1:0]  match_cnt_ff, match_cnt_in;
   logic [STAMP_W-1:0]  match_stamp_ff, match_stamp_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [COUNT_W-1:0]  best_cnt_ff, best_cnt_in;
   logic [STAMP_W-1:0]  best_stamp_ff, best_stamp_in;
   logic [KEY_BITS-1:0] best_key_ff, best_key_in;
   logic [OCC_W-1:0]    occ_ff, occ_in;
   logic [STAMP_W-1:0]  seq_ff, seq_in;

   logic                accept;
   logic                rd_en;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_idx;
   logic [ENT_W-1:0]    wr_data;
   logic [ENT_W-1:0]    rd_data;
   logic [KEY_BITS-1:0] d_key;
   logic [COUNT_W-1:0]  d_cnt;
   logic [STAMP_W-1:0]  d_stamp;
   logic                d_match;
   logic                d_better;
   logic [OCC_W-1:0]    held_m1;
   logic                last_beat;
   logic [CMP_W-1:0]    csr_ext;
   logic [CMP_W-1:0]    cap;
   logic [CMP_W-1:0]    held_ext;
   logic                miss_fill;
   logic                evict;
   logic [COUNT_W-1:0]  hit_cnt;
   logic [IDX_W+SLOT_W-1:0]      slot_wide;
   logic [KEY_BITS+EVKEY_W-1:0]  evkey_wide;

   lfu_mem #(
      .DEPTH  (MAX_SLOTS),
      .ADDR_W (IDX_W),
      .DATA_W (ENT_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // capacity: 0 acts as 1, above MAX_SLOTS acts as MAX_SLOTS
   assign csr_ext  = CMP_W'(cap_cfg);
   assign held_ext = CMP_W'(held_ff);
   always_comb begin
      if (csr_ext == '0) begin
         cap = CMP_W'(1);
      end else if (csr_ext > CMP_W'(MAX_SLOTS)) begin
         cap = CMP_W'(MAX_SLOTS);
      end else begin
         cap = csr_ext;
      end
   end

   assign d_key   = rd_data[ENT_W-1 -: KEY_BITS];
   assign d_cnt   = rd_data[STAMP_W +: COUNT_W];
   assign d_stamp = rd_data[STAMP_W-1:0];
   assign d_match = (d_key == key_ff);
   assign d_better = (rd_idx_ff == '0) || (d_cnt < best_cnt_ff) ||
                     ((d_cnt == best_cnt_ff) && (d_stamp < best_stamp_ff));

   assign held_m1   = held_ff - OCC_W'(1);
   assign last_beat = rd_vld_ff && (rd_idx_ff == held_m1[IDX_W-1:0]);

   assign miss_fill = !found_ff && (held_ext < cap);
   assign evict     = !found_ff && !miss_fill;
   assign hit_cnt   = (match_cnt_ff == COUNT_MAX) ? match_cnt_ff : match_cnt_ff + COUNT_W'(1);

   always_comb begin
      if (found_ff) begin
         wr_idx  = match_idx_ff;
         wr_data = {key_ff, hit_cnt, match_stamp_ff};
      end else if (miss_fill) begin
         wr_idx  = held_ff[IDX_W-1:0];
         wr_data = {key_ff, COUNT_NEW, seq_ff};
      end else begin
         wr_idx  = best_idx_ff;
         wr_data = {key_ff, COUNT_NEW, seq_ff};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (occ_ff == '0) ? ST_UPDATE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_beat) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (res_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = 1'b1;
      accept    = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      res_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
         end
         ST_SCAN: begin
            rd_en = (issue_ff < held_ff);
         end
         ST_UPDATE: begin
            wr_en    = res_free;
            res_load = res_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign slot_wide  = {SLOT_W'(0), wr_idx};
   assign evkey_wide = {EVKEY_W'(0), best_key_ff};

   always_comb begin
      res_beat.hit           = found_ff;
      res_beat.slot          = slot_wide[SLOT_W-1:0];
      res_beat.evicted_valid = evict;
      res_beat.evicted_key   = evict ? evkey_wide[EVKEY_W-1:0] : '0;
   end

   // scan datapath
   always_comb begin
      key_in         = key_ff;
      held_in        = held_ff;
      issue_in       = issue_ff;
      rd_vld_in      = rd_en;
      rd_idx_in      = issue_ff[IDX_W-1:0];
      found_in       = found_ff;
      match_idx_in   = match_idx_ff;
      match_cnt_in   = match_cnt_ff;
      match_stamp_in = match_stamp_ff;
      best_idx_in    = best_idx_ff;
      best_cnt_in    = best_cnt_ff;
      best_stamp_in  = best_stamp_ff;
      best_key_in    = best_key_ff;
      occ_in         = occ_ff;
      seq_in         = seq_ff;
      if (accept) begin
         key_in   = req_key;
         held_in  = occ_ff;
         issue_in = '0;
         found_in = 1'b0;
      end
      if (rd_en) begin
         issue_in = issue_ff + OCC_W'(1);
      end
      if (rd_vld_ff) begin
         if (!found_ff && d_match) begin
            found_in       = 1'b1;
            match_idx_in   = rd_idx_ff;
            match_cnt_in   = d_cnt;
            match_stamp_in = d_stamp;
         end
         if (d_better) begin
            best_idx_in   = rd_idx_ff;
            best_cnt_in   = d_cnt;
            best_stamp_in = d_stamp;
            best_key_in   = d_key;
         end
      end
      if (wr_en) begin
         seq_in = seq_ff + STAMP_W'(1);
         if (miss_fill) begin
            occ_in = occ_ff + OCC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
         occ_ff    <= '0;
         seq_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
         occ_ff    <= occ_in;
         seq_ff    <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      held_ff        <= held_in;
      issue_ff       <= issue_in;
      rd_idx_ff      <= rd_idx_in;
      found_ff       <= found_in;
      match_idx_ff   <= match_idx_in;
      match_cnt_ff   <= match_cnt_in;
      match_stamp_ff <= match_stamp_in;
      best_idx_ff    <= best_idx_in;
      best_cnt_ff    <= best_cnt_in;
      best_stamp_ff  <= best_stamp_in;
      best_key_ff    <= best_key_in;
   end

endmodule

// ===== hw/rtl/lfu_slot_replacement_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_slot_replacement_top
// LFU slot replacement with earliest-insertion tie break, one result per key.
//
//   channel  ports                          direction
//   req      req_valid/req_stall, req_key   in
//   rsp      rsp_valid/rsp_stall, rsp_*     out
//   csr      csr_wr_en, csr_wr_data         in (slots_in_use)
//
// Each key scans every occupied slot, up to MAX_SLOTS of them; the
// slot memory gives one entry per cycle to the scan.
// Reset clears control, occupancy and the insertion sequence; the slot memory
// is not cleared, only occupied slots are ever read.
// The result sits in an output register; the next key is taken while it
// waits, and the slot update holds until that register is free.
// ----------------------------------------------------------------------------
module lfu_slot_replacement_top #(
   parameter int MAX_SLOTS = lfu_pkg::MAX_SLOTS_DEF,
   parameter int KEY_BITS  = lfu_pkg::KEY_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [KEY_BITS-1:0]         req_key,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_hit,
   output logic [lfu_pkg::SLOT_W-1:0]  rsp_slot,
   output logic                        rsp_evicted_valid,
   output logic [lfu_pkg::EVKEY_W-1:0] rsp_evicted_key,
   input  logic                        csr_wr_en,
   input  logic [lfu_pkg::CSR_W-1:0]   csr_wr_data
);

   import lfu_pkg::*;

   logic [CSR_W-1:0] csr_ff, csr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_beat_type     rsp_beat_ff, rsp_beat_in;
   rsp_beat_type     res_beat;
   logic             res_free;
   logic             res_load;

   lfu_ctrl #(
      .MAX_SLOTS (MAX_SLOTS),
      .KEY_BITS  (KEY_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_key   (req_key),
      .cap_cfg   (csr_ff),
      .res_free  (res_free),
      .res_load  (res_load),
      .res_beat  (res_beat)
   );

   assign res_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      csr_in       = csr_wr_en ? csr_wr_data : csr_ff;
      rsp_valid_in = res_load || (rsp_valid_ff && rsp_stall);
      rsp_beat_in  = res_load ? res_beat : rsp_beat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= CSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         csr_ff       <= csr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_beat_ff.hit;
   assign rsp_slot          = rsp_beat_ff.slot;
   assign rsp_evicted_valid = rsp_beat_ff.evicted_valid;
   assign rsp_evicted_key   = rsp_beat_ff.evicted_key;

endmodule
